// ----- rtl/jns_pkg.sv -----
// ----------------------------------------------------------------------------
// jns_pkg
// Shared widths, character codes, status codes and types for the JSON
// number scanner.
// ----------------------------------------------------------------------------
package jns_pkg;

	localparam int MANTISSA_DIGITS = 18;
	localparam int MANT_W          = 60;
	localparam int EXP_W           = 16;
	localparam int PROD_W          = 64;

	function automatic logic [PROD_W-1:0] mant_limit_f();
		logic [PROD_W-1:0] p;
		p = PROD_W'(1);
		for (int i = 0; i < MANTISSA_DIGITS; i++) begin
			p = (p << 3) + (p << 1);
		end
		return p - PROD_W'(1);
	endfunction

	localparam logic [PROD_W-1:0] MANT_LIMIT = mant_limit_f();

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LO_E  = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_EOF = 2'd1;
	localparam logic [1:0] ST_BAD = 2'd2;

	typedef struct packed {
		logic [MANT_W-1:0] mant;
		logic [EXP_W-1:0]  tpow;
		logic              dropped;
	} mant_state_t;

endpackage

// ----- rtl/json_number_scanner.sv -----
// ----------------------------------------------------------------------------
// json_number_scanner
// Scans one JSON number from a byte stream and reports its decimal
// mantissa, exponent and status.
// ----------------------------------------------------------------------------
// Input channel: data_byte and buffer_end under in_valid / in_ready, one text
// byte per request. Output channel: status, negative, mantissa, exponent,
// inexact and byte_not_consumed under out_valid / out_ready, one request per
// finished number (terminator, end of buffer or error). Bytes that do not
// finish a number produce no output.
// Each byte is captured in an input register and then processed by one digit
// step (times-ten add and limit compare on the mantissa) whose result lands in
// the output register. One byte is accepted every cycle while the held output
// is not stalled.
// After a number is reported the scanner returns to its idle state, so the
// next byte starts a new number.
// Reset clears the scan state and both valid flags; the scanner then awaits
// the first byte of a number.
// When the receiver stalls, the held output blocks the byte in the input
// register whether or not it finishes a number; in_ready falls while that
// byte waits and recovers in the cycle the output is taken.
// ----------------------------------------------------------------------------
module json_number_scanner (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       buffer_end,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic                       negative,
	output logic [jns_pkg::MANT_W-1:0] mantissa,
	output logic signed [jns_pkg::EXP_W-1:0] exponent,
	output logic                       inexact,
	output logic                       byte_not_consumed
);
	import jns_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SIGN,
		PH_ZERO,
		PH_INT,
		PH_DOT,
		PH_FRAC,
		PH_EXP_E,
		PH_EXP_SIGN,
		PH_EXP_DIG
	} phase_t;

	phase_t            ph_q, ph_n;
	mant_state_t       ms_q, ms_n, ms_add;
	logic              minus_q, minus_n;
	logic [EXP_W-1:0]  eacc_q, eacc_n, eacc_add;
	logic              eneg_q, eneg_n;

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic              negative_q;
	logic [MANT_W-1:0] mantissa_q;
	logic [EXP_W-1:0]  exponent_q;
	logic              inexact_q;
	logic              nc_q;

	logic              out_free, go;
	logic              dig;
	logic [3:0]        dval;
	logic              add_en, add_frac;
	logic              emit, emit_nc;
	logic [1:0]        emit_st;
	logic [EXP_W-1:0]  exp_res;

	assign out_free = !out_valid_q || out_ready;
	assign go       = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	assign dig  = (data_s1 >= CH_ZERO) && (data_s1 <= CH_NINE);
	assign dval = dig ? data_s1[3:0] : 4'd0;
	assign eacc_add = (eacc_q << 3) + (eacc_q << 1) + EXP_W'(dval);

	jns_mant_acc u_mant (
		.cur   (ms_q),
		.digit (dval),
		.frac  (add_frac),
		.nxt   (ms_add)
	);

	always_comb begin
		ph_n     = ph_q;
		minus_n  = minus_q;
		eacc_n   = eacc_q;
		eneg_n   = eneg_q;
		add_en   = 1'b0;
		add_frac = 1'b0;
		emit     = 1'b0;
		emit_st  = ST_OK;
		emit_nc  = 1'b0;
		unique case (ph_q)
			PH_IDLE, PH_SIGN: begin
				if (ph_q == PH_IDLE && data_s1 == CH_MINUS) begin
					minus_n = 1'b1;
					ph_n    = PH_SIGN;
				end else if (!dig) begin
					emit    = 1'b1;
					emit_st = ST_BAD;
				end else if (dval == 4'd0) begin
					ph_n = PH_ZERO;
				end else begin
					add_en = 1'b1;
					ph_n   = PH_INT;
				end
			end
			PH_ZERO, PH_INT, PH_FRAC: begin
				if (dig && ph_q != PH_ZERO) begin
					add_en   = 1'b1;
					add_frac = (ph_q == PH_FRAC);
				end else if (data_s1 == CH_DOT && ph_q != PH_FRAC) begin
					ph_n = PH_DOT;
				end else if (data_s1 == CH_LO_E || data_s1 == CH_UP_E) begin
					ph_n = PH_EXP_E;
				end else begin
					emit    = 1'b1;
					emit_nc = 1'b1;
				end
			end
			PH_DOT: begin
				if (!dig) begin
					emit    = 1'b1;
					emit_st = ST_BAD;
				end else begin
					add_en   = 1'b1;
					add_frac = 1'b1;
					ph_n     = PH_FRAC;
				end
			end
			PH_EXP_E: begin
				if (data_s1 == CH_MINUS || data_s1 == CH_PLUS) begin
					eneg_n = (data_s1 == CH_MINUS);
					ph_n   = PH_EXP_SIGN;
				end else if (!dig) begin
					emit    = 1'b1;
					emit_st = ST_BAD;
				end else begin
					eacc_n = eacc_add;
					ph_n   = PH_EXP_DIG;
				end
			end
			PH_EXP_SIGN: begin
				if (!dig) begin
					emit    = 1'b1;
					emit_st = ST_BAD;
				end else begin
					eacc_n = eacc_add;
					ph_n   = PH_EXP_DIG;
				end
			end
			PH_EXP_DIG: begin
				if (!dig) begin
					emit    = 1'b1;
					emit_nc = 1'b1;
				end else begin
					eacc_n = eacc_add;
				end
			end
			default: begin
				emit    = 1'b1;
				emit_st = ST_BAD;
			end
		endcase

		ms_n = add_en ? ms_add : ms_q;

		if (!emit && last_s1) begin
			emit = 1'b1;
			if (ph_n == PH_ZERO || ph_n == PH_INT || ph_n == PH_FRAC ||
			    ph_n == PH_EXP_DIG) begin
				emit_st = ST_OK;
			end else begin
				emit_st = ST_EOF;
			end
		end

		exp_res = eneg_n ? (ms_n.tpow - eacc_n) : (ms_n.tpow + eacc_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			data_s1     <= '0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			negative_q  <= 1'b0;
			mantissa_q  <= '0;
			exponent_q  <= '0;
			inexact_q   <= 1'b0;
			nc_q        <= 1'b0;
			ph_q        <= PH_IDLE;
			ms_q        <= '0;
			minus_q     <= 1'b0;
			eacc_q      <= '0;
			eneg_q      <= 1'b0;
		end else begin
			// input register: load on request, drop when processed
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
				data_s1  <= data_byte;
				last_s1  <= buffer_end;
			end else if (go) begin
				valid_s1 <= 1'b0;
			end

			if (go && emit) begin
				out_valid_q <= 1'b1;
				status_q    <= emit_st;
				negative_q  <= (emit_st == ST_OK) & minus_n;
				mantissa_q  <= (emit_st == ST_OK) ? ms_n.mant : '0;
				exponent_q  <= (emit_st == ST_OK) ? exp_res : '0;
				inexact_q   <= (emit_st == ST_OK) & ms_n.dropped;
				nc_q        <= (emit_st == ST_OK) & emit_nc;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (go) begin
				if (emit) begin
					ph_q    <= PH_IDLE;
					ms_q    <= '0;
					minus_q <= 1'b0;
					eacc_q  <= '0;
					eneg_q  <= 1'b0;
				end else begin
					ph_q    <= ph_n;
					ms_q    <= ms_n;
					minus_q <= minus_n;
					eacc_q  <= eacc_n;
					eneg_q  <= eneg_n;
				end
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign negative          = negative_q;
	assign mantissa          = mantissa_q;
	assign exponent          = exponent_q;
	assign inexact           = inexact_q;
	assign byte_not_consumed = nc_q;

endmodule

// ----- rtl/jns_mant_acc.sv -----
// ----------------------------------------------------------------------------
// jns_mant_acc
// Mantissa accumulator step: append a digit if it fits the digit limit, else
// drop it; tpow falls per kept fraction digit, rises per dropped integer one.
// ----------------------------------------------------------------------------
module jns_mant_acc (
	input  jns_pkg::mant_state_t cur,
	input  logic [3:0]           digit,
	input  logic                 frac,
	output jns_pkg::mant_state_t nxt
);
	import jns_pkg::*;

	logic [PROD_W-1:0] wide;
	logic [PROD_W-1:0] prod;
	logic              fits;

	assign wide = PROD_W'(cur.mant);
	assign prod = (wide << 3) + (wide << 1) + PROD_W'(digit);
	assign fits = (prod <= MANT_LIMIT);

	always_comb begin
		nxt = cur;
		if (fits) begin
			nxt.mant = prod[MANT_W-1:0];
			if (frac) begin
				nxt.tpow = cur.tpow - EXP_W'(1);
			end
		end else begin
			nxt.dropped = cur.dropped | (digit != 4'd0);
			if (!frac) begin
				nxt.tpow = cur.tpow + EXP_W'(1);
			end
		end
	end

endmodule
